FILE: hdl/angle_wrap_pid_step_macros.svh
// assertion macros shared by the angle-wrap pid step rtl
`ifndef ANGLE_WRAP_PID_STEP_MACROS_SVH
`define ANGLE_WRAP_PID_STEP_MACROS_SVH

// clocked check, off while reset is asserted
`define AWP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define AWP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hdl/awp_pkg.sv
// shared types and constants for the angle-wrap pid step
package awp_pkg;

  localparam int ANGLE_W     = 19;
  localparam int RATE_W      = 24;
  localparam int GAIN_W      = 24;
  localparam int LIMIT_W     = 31;
  localparam int DRIVE_W     = 32;
  localparam int ERR_W       = 19;
  localparam int DIFF_W      = 20;
  localparam int INTEG_W     = 32;
  localparam int FRAC_W      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 31;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 56;

  // pi and 2*pi in q4.16
  localparam logic signed [DIFF_W-1:0] PI_Q     = 20'sd205887;
  localparam logic signed [DIFF_W-1:0] NEG_PI_Q = -20'sd205887;
  localparam logic signed [DIFF_W-1:0] TWO_PI_Q = 20'sd411775;

  localparam logic [GAIN_W-1:0]  GAIN_P_RST         = 24'd524288;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST         = 24'd327680;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST         = 24'd0;
  localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RST = 31'd0;
  localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RST   = 31'd655360;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_INTEGRAL_LIMIT = 3'd3,
    REG_OUTPUT_LIMIT   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [LIMIT_W-1:0] integral_limit;
    logic [LIMIT_W-1:0] output_limit;
  } cfg_t;

endpackage

FILE: hdl/awp_err_wrap.sv
// angle error, target minus measured, wrapped once into plus or minus pi
module awp_err_wrap (
  input  logic signed [awp_pkg::ANGLE_W-1:0] measured_i,
  input  logic signed [awp_pkg::ANGLE_W-1:0] target_i,
  output logic signed [awp_pkg::ERR_W-1:0]   error_o
);

  logic signed [awp_pkg::DIFF_W-1:0] diff;
  logic signed [awp_pkg::DIFF_W-1:0] wrapped;

  assign diff = awp_pkg::DIFF_W'(target_i) - awp_pkg::DIFF_W'(measured_i);

  always_comb begin
    if (diff > awp_pkg::PI_Q) begin
      wrapped = diff - awp_pkg::TWO_PI_Q;
    end else if (diff < awp_pkg::NEG_PI_Q) begin
      wrapped = diff + awp_pkg::TWO_PI_Q;
    end else begin
      wrapped = diff;
    end
  end

  // one correction always lands inside 19 bits
  assign error_o = wrapped[awp_pkg::ERR_W-1:0];

endmodule

FILE: hdl/awp_pid_core.sv
// p, i and d products, clamped integral update and clamped output sum
module awp_pid_core (
  input  awp_pkg::cfg_t                      cfg_i,
  input  logic signed [awp_pkg::ERR_W-1:0]   error_i,
  input  logic signed [awp_pkg::RATE_W-1:0]  rate_i,
  input  logic signed [awp_pkg::INTEG_W-1:0] integral_i,
  output logic signed [awp_pkg::INTEG_W-1:0] integral_o,
  output logic signed [awp_pkg::DRIVE_W-1:0] drive_o
);

  localparam int PE_W  = awp_pkg::GAIN_W + 1 + awp_pkg::ERR_W;   // gain times error
  localparam int PD_W  = awp_pkg::GAIN_W + 1 + awp_pkg::RATE_W;  // gain times rate
  localparam int TE_W  = PE_W - awp_pkg::FRAC_W;
  localparam int TD_W  = PD_W - awp_pkg::FRAC_W;
  localparam int IS_W  = awp_pkg::INTEG_W + 1;
  localparam int TOT_W = IS_W + 2;

  logic signed [PE_W-1:0]  p_prod;
  logic signed [PE_W-1:0]  i_prod;
  logic signed [PD_W-1:0]  d_prod;
  logic signed [TE_W-1:0]  p_term;
  logic signed [TE_W-1:0]  i_term;
  logic signed [TD_W-1:0]  d_term;
  logic signed [IS_W-1:0]  isum_raw;
  logic signed [IS_W-1:0]  isum_lim;
  logic signed [IS_W-1:0]  isum;
  logic signed [TOT_W-1:0] total_raw;
  logic signed [TOT_W-1:0] total_lim;
  logic signed [TOT_W-1:0] total;

  assign p_prod = $signed({1'b0, cfg_i.gain_p}) * error_i;
  assign i_prod = $signed({1'b0, cfg_i.gain_i}) * error_i;
  assign d_prod = $signed({1'b0, cfg_i.gain_d}) * rate_i;

  // arithmetic shift right by the fraction width, rounds toward minus infinity
  assign p_term = p_prod[PE_W-1:awp_pkg::FRAC_W];
  assign i_term = i_prod[PE_W-1:awp_pkg::FRAC_W];
  assign d_term = d_prod[PD_W-1:awp_pkg::FRAC_W];

  assign isum_raw = IS_W'(integral_i) + IS_W'(i_term);
  assign isum_lim = $signed({{(IS_W-awp_pkg::LIMIT_W){1'b0}}, cfg_i.integral_limit});

  always_comb begin
    if (isum_raw > isum_lim) begin
      isum = isum_lim;
    end else if (isum_raw < -isum_lim) begin
      isum = -isum_lim;
    end else begin
      isum = isum_raw;
    end
  end

  assign integral_o = isum[awp_pkg::INTEG_W-1:0];

  assign total_raw = TOT_W'(p_term) + TOT_W'(isum) + TOT_W'(d_term);
  assign total_lim = $signed({{(TOT_W-awp_pkg::LIMIT_W){1'b0}}, cfg_i.output_limit});

  always_comb begin
    if (total_raw > total_lim) begin
      total = total_lim;
    end else if (total_raw < -total_lim) begin
      total = -total_lim;
    end else begin
      total = total_raw;
    end
  end

  assign drive_o = total[awp_pkg::DRIVE_W-1:0];

endmodule

FILE: hdl/angle_wrap_pid_step.sv
// angle-loop pid step: input register, single-pass pid datapath, result register
//
// usage
//   slave stream carries one sample per transaction: measured angle, target
//   angle (q3.16) and a derivative term (q8.16), all signed. master stream
//   returns the clamped drive and the wrapped error for every sample, in order.
//   gains and limits are written through the plain write port while the
//   block is idle; an unknown register index is ignored.
// pipeline and throughput
//   a sample is held in the input register, the whole pid step is
//   worked out in the cycle that moves it to the result register, and the
//   result register drives the master stream. one sample per cycle is
//   sustained while m_axis_tready stays high; the integral accumulator is
//   updated on the same edge that loads the result register, which lets
//   the next sample follow at once.
// reset
//   gains and limits return to their defaults, the integral sum clears and
//   both pipeline registers are emptied.
// stall
//   while the receiver holds tready low the result is held; one more sample
//   is taken into the input register if it is empty, then s_axis_tready drops.
module angle_wrap_pid_step (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // sample stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // measured_angle [18:0], target_angle [37:19], rate_term [61:38], zero fill
  input  logic [awp_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // drive [31:0], wrapped_error [50:32], zero fill
  output logic [awp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [awp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [awp_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  `include "angle_wrap_pid_step_macros.svh"

  localparam int MEAS_LO = 0;
  localparam int TARG_LO = MEAS_LO + awp_pkg::ANGLE_W;
  localparam int RATE_LO = TARG_LO + awp_pkg::ANGLE_W;
  localparam int OUT_PAD = awp_pkg::OUT_TDATA_W - awp_pkg::DRIVE_W - awp_pkg::ERR_W;

  // configuration registers
  awp_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (awp_pkg::cfg_reg_e'(cfg_index_i))
        awp_pkg::REG_GAIN_P:         cfg_d.gain_p = cfg_data_i[awp_pkg::GAIN_W-1:0];
        awp_pkg::REG_GAIN_I:         cfg_d.gain_i = cfg_data_i[awp_pkg::GAIN_W-1:0];
        awp_pkg::REG_GAIN_D:         cfg_d.gain_d = cfg_data_i[awp_pkg::GAIN_W-1:0];
        awp_pkg::REG_INTEGRAL_LIMIT: cfg_d.integral_limit = cfg_data_i;
        awp_pkg::REG_OUTPUT_LIMIT:   cfg_d.output_limit = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p         <= awp_pkg::GAIN_P_RST;
      cfg_q.gain_i         <= awp_pkg::GAIN_I_RST;
      cfg_q.gain_d         <= awp_pkg::GAIN_D_RST;
      cfg_q.integral_limit <= awp_pkg::INTEGRAL_LIMIT_RST;
      cfg_q.output_limit   <= awp_pkg::OUTPUT_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // pipeline control: the input register drains whenever the result
  // register is empty or being emptied this cycle
  logic in_valid_q, in_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free;
  logic advance;
  logic s_accept;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = s_accept || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input register payload
  logic signed [awp_pkg::ANGLE_W-1:0] meas_q, targ_q;
  logic signed [awp_pkg::RATE_W-1:0]  rate_q;

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      meas_q <= $signed(s_axis_tdata[MEAS_LO +: awp_pkg::ANGLE_W]);
      targ_q <= $signed(s_axis_tdata[TARG_LO +: awp_pkg::ANGLE_W]);
      rate_q <= $signed(s_axis_tdata[RATE_LO +: awp_pkg::RATE_W]);
    end
  end

  // datapath
  logic signed [awp_pkg::ERR_W-1:0]   err;
  logic signed [awp_pkg::INTEG_W-1:0] integral_q, integral_d;
  logic signed [awp_pkg::INTEG_W-1:0] integral_next;
  logic signed [awp_pkg::DRIVE_W-1:0] drive;

  awp_err_wrap u_err_wrap (
    .measured_i (meas_q),
    .target_i   (targ_q),
    .error_o    (err)
  );

  awp_pid_core u_pid_core (
    .cfg_i      (cfg_q),
    .error_i    (err),
    .rate_i     (rate_q),
    .integral_i (integral_q),
    .integral_o (integral_next),
    .drive_o    (drive)
  );

  // accumulator moves only with a transaction into the result register
  assign integral_d = advance ? integral_next : integral_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q <= '0;
    end else begin
      integral_q <= integral_d;
    end
  end

  // result register payload
  logic signed [awp_pkg::DRIVE_W-1:0] drive_q;
  logic signed [awp_pkg::ERR_W-1:0]   err_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      drive_q <= drive;
      err_q   <= err;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD{1'b0}}, err_q, drive_q};

  // checks
  `AWP_ASSERT(a_integral_held, !advance |=> $stable(integral_q),
              "integral sum changed without a transaction")
  `AWP_ASSERT(a_integral_in_limit,
              advance |=> ((integral_q <= $signed({1'b0, $past(cfg_q.integral_limit)}))
                && (integral_q >= -$signed({1'b0, $past(cfg_q.integral_limit)}))),
              "integral sum left its clamp range")
  `AWP_ASSERT(a_advance_fills_out, advance |=> m_axis_tvalid,
              "result register not loaded after a transaction")
  `AWP_ASSERT_ALWAYS(a_ready_low_means_full,
              !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready),
              "sample stream stalled with room in the pipeline")

endmodule
